/* sv/ffsa_pkg.sv */
// Shared types and constants for the first-fit segment allocator.
`default_nettype none

package ffsa_pkg;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Heap order loaded at reset.
    localparam logic [4:0] RESET_ORDER = 5'd26;

    // Field widths fixed by the stream format.
    localparam int SIZE_W   = 27;
    localparam int OFFSET_W = 26;
    localparam int ORDER_W  = 5;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } ffsa_status_t;

    // Operation that every cell of the segment ring performs.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_ROTATE = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } ffsa_cell_op_t;

endpackage

`default_nettype wire

/* sv/ffsa_cell.sv */
// One cell of the segment ring: holds a single table entry (start, length).
`default_nettype none

module ffsa_cell #(
    parameter int SW  = 26,
    parameter int LW  = 27,
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire logic                  clk,
    input  wire ffsa_pkg::ffsa_cell_op_t op,
    input  wire logic [IW-1:0]         pos,
    input  wire logic [SW-1:0]         left_start,
    input  wire logic [LW-1:0]         left_len,
    input  wire logic [SW-1:0]         right_start,
    input  wire logic [LW-1:0]         right_len,
    input  wire logic [SW-1:0]         new_start,
    input  wire logic [LW-1:0]         new_len,
    output logic      [SW-1:0]         seg_start,
    output logic      [LW-1:0]         seg_len
);

    logic [SW-1:0] start_reg;
    logic [LW-1:0] len_reg;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    // Rotation moves every entry one place toward cell 0; insert and delete
    // open or close a slot at the broadcast position.
    always_ff @(posedge clk)
    begin
        unique case (op)
            ffsa_pkg::CELL_HOLD:
            begin
            end
            ffsa_pkg::CELL_ROTATE:
            begin
                start_reg <= right_start;
                len_reg   <= right_len;
            end
            ffsa_pkg::CELL_INSERT:
            begin
                if (MY_IDX > pos)
                begin
                    start_reg <= left_start;
                    len_reg   <= left_len;
                end
                else if (MY_IDX == pos)
                begin
                    start_reg <= new_start;
                    len_reg   <= new_len;
                end
            end
            ffsa_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= pos)
                begin
                    start_reg <= right_start;
                    len_reg   <= right_len;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign seg_start = start_reg;
    assign seg_len   = len_reg;

endmodule

`default_nettype wire

/* sv/ffsa_ctrl.sv */
// Request sequencer: scans the cell ring, decides placement and edits the table.
`default_nettype none

module ffsa_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_ORDER    = 26,
    parameter int SW           = 26,
    parameter int LW           = 27,
    parameter int IW           = 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Configuration write.
    input  wire logic                    cfg_wr_en,
    input  wire logic [4:0]              cfg_wr_data,
    // Request side.
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    in_req_type,
    input  wire logic [26:0]             in_alloc_size,
    input  wire logic [25:0]             in_free_offset,
    // Result side.
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   out_status,
    output logic [25:0]                  out_seg_offset,
    output logic [26:0]                  out_free_bytes,
    // Cell ring.
    input  wire logic [SW-1:0]           head_start,
    input  wire logic [LW-1:0]           head_len,
    output ffsa_pkg::ffsa_cell_op_t      cell_op,
    output logic [IW-1:0]                cell_pos,
    output logic [SW-1:0]                new_start,
    output logic [LW-1:0]                new_len
);

    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW   = $clog2(MAX_ORDER + 1);
    localparam int CW   = (LW > ffsa_pkg::SIZE_W) ? LW : ffsa_pkg::SIZE_W;
    localparam logic [IW-1:0]   LAST_IDX = IW'(MAX_SEGMENTS - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_SEGMENTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIT,
        S_DONE
    } state_t;

    // Heap size for a given order, saturated at the largest supported order.
    function automatic logic [LW-1:0] heap_of(input logic [4:0] order);
        logic [EW-1:0] eff;
        eff = (32'(order) > MAX_ORDER) ? EW'(MAX_ORDER) : EW'(order);
        return LW'(1) << eff;
    endfunction

    state_t                 state_reg;
    logic [4:0]             order_reg;
    logic [CNTW-1:0]        count_reg;
    logic [LW-1:0]          free_count_reg;
    logic [IW-1:0]          k_reg;
    logic                   found_reg;
    logic [IW-1:0]          pos_reg;
    logic                   req_type_reg;
    logic [26:0]            size_reg;
    logic [25:0]            offset_reg;
    logic [LW-1:0]          off_reg;
    logic [LW-1:0]          flen_reg;
    ffsa_pkg::ffsa_status_t res_status_reg;
    logic [25:0]            res_offset_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [25:0]            out_offset_reg;
    logic [26:0]            out_free_reg;

    logic                   accept;
    logic                   no_space_now;
    logic                   full_now;
    logic                   entry_live;
    logic                   gap_fit;
    logic                   offset_hit;
    logic [LW-1:0]          off_next;
    logic [LW-1:0]          heap_now;
    logic                   tail_fit;
    logic                   edit_ok;
    logic [LW:0]            freed_sum;
    logic [LW-1:0]          free_next;

    // Early checks on the incoming request.
    assign accept       = in_valid && (state_reg == S_IDLE);
    assign no_space_now = (in_alloc_size == '0) ||
                          (CW'(in_alloc_size) > CW'(free_count_reg));
    assign full_now     = (count_reg >= FULL_CNT);

    // Per-step test on the entry now sitting in cell 0.
    assign entry_live = CNTW'(k_reg) < count_reg;
    assign gap_fit    = (CW'(head_start) >= CW'(off_reg)) &&
                        ((CW'(head_start) - CW'(off_reg)) >= CW'(size_reg));
    assign offset_hit = (CW'(head_start) == CW'(offset_reg));
    assign off_next   = LW'(head_start) + head_len;

    // Placement after the last segment and free-count update on release.
    assign heap_now  = heap_of(order_reg);
    assign tail_fit  = (CW'(heap_now) - CW'(off_reg)) >= CW'(size_reg);
    assign edit_ok   = found_reg || ((req_type_reg == ffsa_pkg::REQ_ALLOC) && tail_fit);
    assign freed_sum = (LW+1)'(free_count_reg) + (LW+1)'(flen_reg);
    assign free_next = (freed_sum > (LW+1)'(heap_now)) ? heap_now : LW'(freed_sum);

    // Ring command: rotate while scanning, edit once in the fit cycle if a slot was found or the tail fits.
    always_comb
    begin
        cell_op = ffsa_pkg::CELL_HOLD;
        if (state_reg == S_SCAN)
        begin
            cell_op = ffsa_pkg::CELL_ROTATE;
        end
        else if ((state_reg == S_FIT) && edit_ok)
        begin
            cell_op = (req_type_reg == ffsa_pkg::REQ_ALLOC) ? ffsa_pkg::CELL_INSERT
                                                            : ffsa_pkg::CELL_DELETE;
        end
    end

    assign cell_pos  = found_reg ? pos_reg : IW'(count_reg);
    assign new_start = SW'(off_reg);
    assign new_len   = LW'(size_reg);

    // Sequencer state, table bookkeeping and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            order_reg      <= ffsa_pkg::RESET_ORDER;
            count_reg      <= '0;
            free_count_reg <= heap_of(ffsa_pkg::RESET_ORDER);
            k_reg          <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // The done state reloads the result register itself.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // A register write empties the table and refills the free count.
            if (cfg_wr_en)
            begin
                order_reg      <= cfg_wr_data;
                count_reg      <= '0;
                free_count_reg <= heap_of(cfg_wr_data);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_type_reg   <= in_req_type;
                        size_reg       <= in_alloc_size;
                        offset_reg     <= in_free_offset;
                        off_reg        <= '0;
                        k_reg          <= '0;
                        found_reg      <= 1'b0;
                        res_offset_reg <= '0;
                        if ((in_req_type == ffsa_pkg::REQ_ALLOC) && no_space_now)
                        begin
                            res_status_reg <= ffsa_pkg::ST_NO_SPACE;
                            state_reg      <= S_DONE;
                        end
                        else if ((in_req_type == ffsa_pkg::REQ_ALLOC) && full_now)
                        begin
                            res_status_reg <= ffsa_pkg::ST_TABLE_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    if (!found_reg && entry_live)
                    begin
                        if (req_type_reg == ffsa_pkg::REQ_ALLOC)
                        begin
                            if (gap_fit)
                            begin
                                found_reg <= 1'b1;
                                pos_reg   <= k_reg;
                            end
                            else
                            begin
                                off_reg <= off_next;
                            end
                        end
                        else if (offset_hit)
                        begin
                            found_reg <= 1'b1;
                            pos_reg   <= k_reg;
                            flen_reg  <= head_len;
                        end
                    end
                    k_reg <= k_reg + IW'(1);
                    if (k_reg == LAST_IDX)
                    begin
                        state_reg <= S_FIT;
                    end
                end

                S_FIT:
                begin
                    if (req_type_reg == ffsa_pkg::REQ_ALLOC)
                    begin
                        if (edit_ok)
                        begin
                            res_status_reg <= ffsa_pkg::ST_OK;
                            res_offset_reg <= 26'(off_reg);
                            count_reg      <= count_reg + CNTW'(1);
                            free_count_reg <= free_count_reg - LW'(size_reg);
                        end
                        else
                        begin
                            res_status_reg <= ffsa_pkg::ST_NO_SPACE;
                        end
                    end
                    else if (found_reg)
                    begin
                        res_status_reg <= ffsa_pkg::ST_OK;
                        count_reg      <= count_reg - CNTW'(1);
                        free_count_reg <= free_next;
                    end
                    else
                    begin
                        res_status_reg <= ffsa_pkg::ST_NOT_FOUND;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_offset_reg <= res_offset_reg;
                        out_free_reg   <= 27'(free_count_reg);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_seg_offset = out_offset_reg;
    assign out_free_bytes = out_free_reg;

endmodule

`default_nettype wire

/* sv/first_fit_segment_allocator.sv */
// A scanned request passes through the scan, fit and done states before its result is registered;
// an allocate rejected for size or a full table goes from idle straight to the done state.
// One transaction is in flight at a time, and a scanned request waits for one full rotation of the
// segment cell ring past the sequencer at one entry per cycle.
// Reset empties the table and loads a heap order of 26; the entry cells
// themselves are not cleared, and entries above the segment count are unused.
`default_nettype none

module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_ORDER    = 26
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: heap_order.
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // alloc_size[26:0], free_offset[52:27], zero pad
    input  wire logic [0:0]  s_axis_tuser,  // req_type[0]
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // seg_offset[25:0], free_bytes[52:26], zero pad
    output logic [1:0]       m_axis_tuser   // status[1:0]
);

    localparam int SW = MAX_ORDER;
    localparam int LW = MAX_ORDER + 1;
    localparam int IW = $clog2(MAX_SEGMENTS);

    ffsa_pkg::ffsa_cell_op_t cell_op;
    logic [IW-1:0]           cell_pos;
    logic [SW-1:0]           new_start;
    logic [LW-1:0]           new_len;
    logic [SW-1:0]           ring_start [MAX_SEGMENTS];
    logic [LW-1:0]           ring_len   [MAX_SEGMENTS];
    logic [1:0]              res_status;
    logic [25:0]             res_offset;
    logic [26:0]             res_free;

    // Sequencer with the configuration register and the result register.
    ffsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_ORDER    (MAX_ORDER),
        .SW           (SW),
        .LW           (LW),
        .IW           (IW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_req_type    (s_axis_tuser[0]),
        .in_alloc_size  (s_axis_tdata[26:0]),
        .in_free_offset (s_axis_tdata[52:27]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (res_status),
        .out_seg_offset (res_offset),
        .out_free_bytes (res_free),
        .head_start     (ring_start[0]),
        .head_len       (ring_len[0]),
        .cell_op        (cell_op),
        .cell_pos       (cell_pos),
        .new_start      (new_start),
        .new_len        (new_len)
    );

    // Ring of table cells; cell 0 is the one the sequencer inspects.
    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        ffsa_cell #(
            .SW  (SW),
            .LW  (LW),
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .op          (cell_op),
            .pos         (cell_pos),
            .left_start  (ring_start[(i + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
            .left_len    (ring_len[(i + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
            .right_start (ring_start[(i + 1) % MAX_SEGMENTS]),
            .right_len   (ring_len[(i + 1) % MAX_SEGMENTS]),
            .new_start   (new_start),
            .new_len     (new_len),
            .seg_start   (ring_start[i]),
            .seg_len     (ring_len[i])
        );
    end

    // Pack the result fields onto the output stream.
    assign m_axis_tdata = {3'b000, res_free, res_offset};
    assign m_axis_tuser = res_status;

endmodule

`default_nettype wire

/* dv/tb_first_fit_segment_allocator.sv */
// Self-checking testbench for the first-fit segment allocator stream block.
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator;

    localparam int MAX_SEGMENTS   = 64;
    localparam int MAX_ORDER      = 26;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 175;
    localparam int DRAIN_CYCLES   = MAX_SEGMENTS + 16;
    localparam int TIMEOUT_CYCLES = 5000;
    localparam int HOLD_CYCLES    = 600;

    localparam logic [ffsa_pkg::SIZE_W-1:0] HEAP_TOP = 27'd67108864;

    // One result transaction as the block reports it.
    typedef struct packed {
        ffsa_pkg::ffsa_status_t          status;
        logic [ffsa_pkg::OFFSET_W-1:0]   seg_offset;
        logic [ffsa_pkg::SIZE_W-1:0]     free_bytes;
    } alloc_result_t;

    // One row of the directed request table.
    typedef struct packed {
        logic                            kind;
        logic [ffsa_pkg::SIZE_W-1:0]     size;
        logic [ffsa_pkg::OFFSET_W-1:0]   offset;
        logic                            typed;
        alloc_result_t                   want;
    } request_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ffsa_pkg::ORDER_W-1:0]   cfg_wr_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [55:0]                    s_axis_tdata = '0;  // alloc_size[26:0], free_offset[52:27], zero pad
    logic [0:0]                     s_axis_tuser = '0;  // req_type[0]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [55:0]                    m_axis_tdata;       // seg_offset[25:0], free_bytes[52:26], zero pad
    logic [1:0]                     m_axis_tuser;       // status[1:0]

    // Shadow copy of the heap: segment table, free count and heap order.
    logic [ffsa_pkg::OFFSET_W-1:0]  seg_base [MAX_SEGMENTS];
    logic [ffsa_pkg::SIZE_W-1:0]    seg_span [MAX_SEGMENTS];
    int                             seg_used;
    logic [ffsa_pkg::SIZE_W-1:0]    seg_free;
    logic [ffsa_pkg::ORDER_W-1:0]   heap_order_q;

    alloc_result_t        pending_results [$];
    int unsigned          mismatches = 0;
    int unsigned          results_seen = 0;
    int unsigned          items_sent = 0;
    int unsigned          quiet_cycles = 0;

    first_fit_segment_allocator #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_ORDER    (MAX_ORDER)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Heap size in bytes; orders above the maximum saturate.
    function automatic longint heap_size();
        return longint'(1) << ((heap_order_q > MAX_ORDER) ? MAX_ORDER : heap_order_q);
    endfunction

    // Apply one request to the shadow heap and return the result it must produce.
    function automatic alloc_result_t predict_request(
        input logic                          kind,
        input logic [ffsa_pkg::SIZE_W-1:0]   size,
        input logic [ffsa_pkg::OFFSET_W-1:0] offset);
        alloc_result_t res;
        longint        heap;
        longint        cursor;
        int            slot;
        int            i;
        bit            placed;
        res.status     = ffsa_pkg::ST_OK;
        res.seg_offset = '0;
        heap           = heap_size();
        if (kind == ffsa_pkg::REQ_ALLOC)
        begin
            if (size == 0 || size > seg_free)
                res.status = ffsa_pkg::ST_NO_SPACE;
            else if (seg_used >= MAX_SEGMENTS)
                res.status = ffsa_pkg::ST_TABLE_FULL;
            else
            begin
                // First gap in front of an existing segment that is large enough.
                cursor = 0;
                slot   = seg_used;
                placed = 1'b0;
                for (i = 0; i < seg_used && !placed; i++)
                begin
                    if (longint'(seg_base[i]) >= cursor &&
                        longint'(seg_base[i]) - cursor >= longint'(size))
                    begin
                        slot   = i;
                        placed = 1'b1;
                    end
                    else
                        cursor = longint'(seg_base[i]) + longint'(seg_span[i]);
                end
                // Otherwise the tail after the last segment has to hold it.
                if (!placed && (cursor > heap || heap - cursor < longint'(size)))
                    res.status = ffsa_pkg::ST_NO_SPACE;
                else
                begin
                    for (i = seg_used; i > slot; i--)
                    begin
                        seg_base[i] = seg_base[i-1];
                        seg_span[i] = seg_span[i-1];
                    end
                    seg_base[slot] = ffsa_pkg::OFFSET_W'(cursor);
                    seg_span[slot] = size;
                    seg_used++;
                    seg_free       = seg_free - size;
                    res.seg_offset = ffsa_pkg::OFFSET_W'(cursor);
                end
            end
        end
        else
        begin
            slot = -1;
            for (i = 0; i < seg_used && slot < 0; i++)
                if (seg_base[i] == offset)
                    slot = i;
            if (slot < 0)
                res.status = ffsa_pkg::ST_NOT_FOUND;
            else
            begin
                // Return the bytes, never beyond the heap size, and close the hole.
                if (longint'(seg_free) + longint'(seg_span[slot]) > heap)
                    seg_free = ffsa_pkg::SIZE_W'(heap);
                else
                    seg_free = seg_free + seg_span[slot];
                for (i = slot; i + 1 < seg_used; i++)
                begin
                    seg_base[i] = seg_base[i+1];
                    seg_span[i] = seg_span[i+1];
                end
                seg_used--;
            end
        end
        res.free_bytes = seg_free;
        return res;
    endfunction

    function automatic request_row_t request_row(
        input logic                          kind,
        input logic [ffsa_pkg::SIZE_W-1:0]   size,
        input logic [ffsa_pkg::OFFSET_W-1:0] offset,
        input logic                          typed,
        input ffsa_pkg::ffsa_status_t        status,
        input logic [ffsa_pkg::OFFSET_W-1:0] seg_offset,
        input logic [ffsa_pkg::SIZE_W-1:0]   free_bytes);
        request_row_t row;
        row.kind            = kind;
        row.size            = size;
        row.offset          = offset;
        row.typed           = typed;
        row.want.status     = status;
        row.want.seg_offset = seg_offset;
        row.want.free_bytes = free_bytes;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one request transaction; called at a falling edge and returns at one.
    task automatic send_request(input logic                          kind,
                                input logic [ffsa_pkg::SIZE_W-1:0]   size,
                                input logic [ffsa_pkg::OFFSET_W-1:0] offset,
                                input logic                          typed,
                                input alloc_result_t                 typed_want);
        alloc_result_t predicted;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, offset, size};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_request(kind, size, offset);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
        @(negedge clk);
        // Mostly back to back, some short gaps and a few long ones.
        gap = 0;
        if (((items_sent / 200) % 4) != 1 && $urandom_range(0, 99) >= 70)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write the heap order; this also empties the heap.
    task automatic write_heap_order(input logic [ffsa_pkg::ORDER_W-1:0] order);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        heap_order_q = order;
        seg_used     = 0;
        seg_free     = ffsa_pkg::SIZE_W'(heap_size());
    endtask

    // Result sink: random stalls, quiet stretches and two long hold-offs.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ((holds_done == 0 && results_seen >= 400) ||
                (holds_done == 1 && results_seen >= 1300))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (((results_seen / 150) % 4) != 3 && $urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing outstanding, status", m_axis_tuser, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[25:0] !== want.seg_offset)
                    report_mismatch("seg_offset", m_axis_tdata[25:0], want.seg_offset);
                if (m_axis_tdata[52:26] !== want.free_bytes)
                    report_mismatch("free_bytes", m_axis_tdata[52:26], want.free_bytes);
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= TIMEOUT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        request_row_t                   rows [$];
        logic [ffsa_pkg::ORDER_W-1:0]   order;
        logic                           kind;
        logic [ffsa_pkg::SIZE_W-1:0]    size;
        logic [ffsa_pkg::OFFSET_W-1:0]  offset;
        int                             phase;
        int                             k;
        int                             r;
        int                             span;
        longint                         heap;

        // Shadow heap starts as the block does after reset.
        heap_order_q = ffsa_pkg::RESET_ORDER;
        seg_used     = 0;
        seg_free     = ffsa_pkg::SIZE_W'(heap_size());

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests on the reset heap of 2^26 bytes.
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd0, 26'd0, 1'b1,
                                   ffsa_pkg::ST_NO_SPACE, 26'd0, HEAP_TOP));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'h7FFFFFF, 26'd0, 1'b1,
                                   ffsa_pkg::ST_NO_SPACE, 26'd0, HEAP_TOP));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'h3FFFFFF, 1'b1,
                                   ffsa_pkg::ST_NOT_FOUND, 26'd0, HEAP_TOP));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, HEAP_TOP, 26'd0, 1'b1,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd1, 26'd0, 1'b1,
                                   ffsa_pkg::ST_NO_SPACE, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'd0, 1'b1,
                                   ffsa_pkg::ST_OK, 26'd0, HEAP_TOP));
        // Build a fragmented table, then refill the holes first fit.
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd16, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd32, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd8, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'd16, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd40, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd20, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd12, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'd1, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        // Enough free bytes in total, but neither the hole nor the tail holds it.
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, HEAP_TOP - 27'd90, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'h2AAAAAA, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd16, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'h1555555, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        // The tail exactly fits the rest of the heap.
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, HEAP_TOP - 27'd96, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd1, 26'd0, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        rows.push_back(request_row(ffsa_pkg::REQ_FREE, 27'd0, 26'd96, 1'b0,
                                   ffsa_pkg::ST_OK, 26'd0, 27'd0));
        // Single-byte allocates fill the table until the last ones find it full.
        for (k = 0; k < MAX_SEGMENTS + 2; k++)
            rows.push_back(request_row(ffsa_pkg::REQ_ALLOC, 27'd1, 26'd0, 1'b0,
                                       ffsa_pkg::ST_OK, 26'd0, 27'd0));

        foreach (rows[k])
            send_request(rows[k].kind, rows[k].size, rows[k].offset, rows[k].typed, rows[k].want);

        // Random phases, each on a freshly configured heap.
        for (phase = 0; phase < PHASES; phase++)
        begin
            unique case (phase)
                0:       order = 5'd4;
                1:       order = 5'd31;
                2:       order = 5'd12;
                3:       order = 5'd0;
                4:       order = 5'd8;
                5:       order = 5'd26;
                6:       order = 5'd16;
                7:       order = 5'd27;
                8:       order = 5'd10;
                default: order = ffsa_pkg::ORDER_W'($urandom_range(4, 26));
            endcase
            drain_results();
            write_heap_order(order);
            heap = heap_size();
            span = int'(heap >> 7);
            if (span < 1)
                span = 1;

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Allocation-heavy first part fills the table; the rest drains it.
                if ($urandom_range(0, 99) < ((k < 100) ? 90 : 25))
                begin
                    kind   = ffsa_pkg::REQ_ALLOC;
                    offset = ffsa_pkg::OFFSET_W'($urandom());
                    r      = $urandom_range(0, 99);
                    if (r < 70)
                        size = ffsa_pkg::SIZE_W'($urandom_range(1, span));
                    else if (r < 85)
                        size = ffsa_pkg::SIZE_W'($urandom_range(1, int'(heap >> 2) + 1));
                    else if (r < 90)
                        size = ffsa_pkg::SIZE_W'($urandom_range(1, int'(heap)));
                    else if (r < 94)
                        size = seg_free;
                    else if (r < 97)
                        size = '0;
                    else
                        size = ffsa_pkg::SIZE_W'($urandom());
                end
                else
                begin
                    kind = ffsa_pkg::REQ_FREE;
                    size = ffsa_pkg::SIZE_W'($urandom());
                    r    = $urandom_range(0, 99);
                    if (seg_used > 0 && r < 80)
                        offset = seg_base[$urandom_range(0, seg_used - 1)];
                    else if (seg_used > 0 && r < 90)
                        offset = seg_base[$urandom_range(0, seg_used - 1)] + 1'b1;
                    else
                        offset = ffsa_pkg::OFFSET_W'($urandom());
                end
                send_request(kind, size, offset, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
